@@ rtl/tswm_pkg.sv @@
`default_nettype none
package tswm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NPAR = 4;
    localparam int POW_SHIFT = 2 * FRAC_BITS + 32;
    localparam logic [127:0] POW_NUM = 128'(1) << POW_SHIFT;
    localparam logic [30:0] ERR_MAX = 31'h7FFF_FFFF;
    localparam logic [9:0] HIT_MAX = 10'd1023;
    localparam int PAR_BITS = 63;
    localparam int IN_BITS = 276;
    localparam int OUT_BITS = 280;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQUARE,
        ST_WEIGHT,
        ST_TERM,
        ST_MEAN,
        ST_MDIV,
        ST_EDIV,
        ST_ROOT,
        ST_EMIT
    } tswm_state_t;

endpackage
`default_nettype wire

@@ rtl/track_segment_weighted_merge_unit.sv @@
// Inverse-variance weighted merge of track segments. One segment is taken per transfer
// and one merged result is returned per segment. The four parameters are handled one
// after another on a shared bit-serial multiplier, a restoring divider and a
// square-root unit. A parameter with a nonzero error uses two multiplies, three
// divides and one root; with a zero error it uses two divides and one root, or none
// when no measurement is held. The input is taken only while the block is idle;
// the finished result sits in an output register, so the next segment may enter
// while it waits.
`default_nettype none
module track_segment_weighted_merge_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pt_value, pt_error, psi_value, psi_error, tanl_value, tanl_error,
    // zpos_value, zpos_error, inner_row, outer_row, hit_count, zero pad
    input  wire logic [279:0] s_tdata,
    // first_piece
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // merged_pt, merged_pt_error, merged_psi, merged_psi_error, merged_tanl,
    // merged_tanl_error, merged_zpos, merged_zpos_error, span_inner, span_outer,
    // hit_total, bad_error_mask
    output logic [279:0]      m_tdata
);
    import tswm_pkg::*;

    tswm_state_t state_reg, state_next;
    logic [1:0]  par_reg, par_next;

    logic [IN_BITS-1:0] in_reg;
    logic               first_reg;
    logic [63:0]        wsum_reg [NPAR];
    logic [63:0]        tsum_reg [NPAR];
    logic [31:0]        mean_reg [NPAR];
    logic [30:0]        err_reg  [NPAR];
    logic [63:0]        w_reg;
    logic [6:0]         inner_reg;
    logic [6:0]         outer_reg;
    logic [9:0]         hits_reg;
    logic [3:0]         mask_reg;
    logic               m_valid_reg;
    logic [OUT_BITS-1:0] m_data_reg;

    logic        accept;
    logic [31:0] cur_val;
    logic [30:0] cur_err;
    logic [31:0] cur_mag;
    logic [63:0] cur_wsum;
    logic [63:0] cur_tsum;
    logic [63:0] tsum_mag;

    logic         mul_start, mul_busy, mul_done;
    logic [63:0]  mul_a, mul_hi;
    logic [31:0]  mul_b, mul_lo;
    logic         div_start, div_busy, div_done;
    logic [127:0] div_num;
    logic [63:0]  div_den, div_q;
    logic         sqrt_start, sqrt_busy, sqrt_done;
    logic [31:0]  sqrt_root;

    logic [63:0] term;
    logic [64:0] wadd;
    logic [64:0] tadd;
    logic [63:0] wsum_new;
    logic [63:0] tsum_new;
    logic [31:0] mean_val;
    logic [10:0] hsum;
    logic        emit_ok;

    assign accept  = s_tvalid && s_tready;
    assign emit_ok = !m_valid_reg || m_tready;

    always_comb begin
        cur_val  = in_reg[32'(par_reg) * PAR_BITS +: 32];
        cur_err  = in_reg[32'(par_reg) * PAR_BITS + 32 +: 31];
        cur_mag  = cur_val[31] ? (32'd0 - cur_val) : cur_val;
        cur_wsum = wsum_reg[par_reg];
        cur_tsum = tsum_reg[par_reg];
        tsum_mag = cur_tsum[63] ? (64'd0 - cur_tsum) : cur_tsum;
        term     = cur_val[31] ? (64'd0 - mul_hi) : mul_hi;
        wadd     = {1'b0, cur_wsum} + {1'b0, w_reg};
        tadd     = {cur_tsum[63], cur_tsum} + {term[63], term};
        wsum_new = wadd[64] ? '1 : wadd[63:0];
        if (tadd[64] != tadd[63]) begin
            tsum_new = tadd[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            tsum_new = tadd[63:0];
        end
        if (cur_tsum[63]) begin
            mean_val = (div_q > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - div_q[31:0]);
        end else begin
            mean_val = (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
        end
        hsum = {1'b0, hits_reg} + {1'b0, s_tdata[275:266]};
    end

    always_comb begin
        state_next = state_reg;
        par_next   = par_reg;
        s_tready   = 1'b0;
        mul_start  = 1'b0;
        mul_a      = div_q;
        mul_b      = cur_mag;
        div_start  = 1'b0;
        div_num    = POW_NUM;
        div_den    = cur_wsum;
        sqrt_start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                    par_next   = '0;
                end
            end
            ST_CHECK: begin
                mul_a = {33'd0, cur_err};
                mul_b = {1'b0, cur_err};
                if (cur_err == '0) begin
                    state_next = ST_MEAN;
                end else begin
                    mul_start  = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                div_den = {mul_hi[31:0], mul_lo};
                if (mul_done) begin
                    div_start  = 1'b1;
                    state_next = ST_WEIGHT;
                end
            end
            ST_WEIGHT: begin
                if (div_done) begin
                    mul_start  = 1'b1;
                    state_next = ST_TERM;
                end
            end
            ST_TERM: begin
                if (mul_done) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN: begin
                div_num = {32'd0, tsum_mag, 32'd0};
                if (cur_wsum == '0) begin
                    if (par_reg == 2'(NPAR - 1)) begin
                        state_next = ST_EMIT;
                    end else begin
                        par_next   = par_reg + 2'd1;
                        state_next = ST_CHECK;
                    end
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_MDIV;
                end
            end
            ST_MDIV: begin
                if (div_done) begin
                    div_start  = 1'b1;
                    state_next = ST_EDIV;
                end
            end
            ST_EDIV: begin
                if (div_done) begin
                    sqrt_start = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (sqrt_done) begin
                    if (par_reg == 2'(NPAR - 1)) begin
                        state_next = ST_EMIT;
                    end else begin
                        par_next   = par_reg + 2'd1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            par_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NPAR; i++) begin
                wsum_reg[i] <= '0;
                tsum_reg[i] <= '0;
            end
            inner_reg <= '0;
            outer_reg <= '0;
            hits_reg  <= '0;
        end else begin
            state_reg <= state_next;
            par_reg   <= par_next;
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_EMIT && emit_ok) begin
                m_valid_reg <= 1'b1;
            end
            if (accept) begin
                if (s_tuser) begin
                    inner_reg <= s_tdata[258:252];
                    outer_reg <= s_tdata[265:259];
                    hits_reg  <= s_tdata[275:266];
                end else begin
                    if (s_tdata[258:252] < inner_reg) begin
                        inner_reg <= s_tdata[258:252];
                    end
                    if (s_tdata[265:259] > outer_reg) begin
                        outer_reg <= s_tdata[265:259];
                    end
                    hits_reg <= (hsum > {1'b0, HIT_MAX}) ? HIT_MAX : hsum[9:0];
                end
            end
            if (state_reg == ST_CHECK && cur_err == '0 && first_reg) begin
                wsum_reg[par_reg] <= '0;
                tsum_reg[par_reg] <= '0;
            end
            if (state_reg == ST_TERM && mul_done) begin
                if (first_reg) begin
                    wsum_reg[par_reg] <= w_reg;
                    tsum_reg[par_reg] <= term;
                end else begin
                    wsum_reg[par_reg] <= wsum_new;
                    tsum_reg[par_reg] <= tsum_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg    <= s_tdata[IN_BITS-1:0];
            first_reg <= s_tuser;
            mask_reg  <= '0;
        end
        if (state_reg == ST_CHECK && cur_err == '0) begin
            mask_reg[par_reg] <= 1'b1;
        end
        if (state_reg == ST_WEIGHT && div_done) begin
            w_reg <= div_q;
        end
        if (state_reg == ST_MEAN && cur_wsum == '0) begin
            mean_reg[par_reg] <= '0;
            err_reg[par_reg]  <= ERR_MAX;
        end
        if (state_reg == ST_MDIV && div_done) begin
            mean_reg[par_reg] <= mean_val;
        end
        if (state_reg == ST_ROOT && sqrt_done) begin
            err_reg[par_reg] <= sqrt_root[31] ? ERR_MAX : sqrt_root[30:0];
        end
        if (state_reg == ST_EMIT && emit_ok) begin
            for (int i = 0; i < NPAR; i++) begin
                m_data_reg[i * PAR_BITS +: 32]      <= mean_reg[i];
                m_data_reg[i * PAR_BITS + 32 +: 31] <= err_reg[i];
            end
            m_data_reg[258:252] <= inner_reg;
            m_data_reg[265:259] <= outer_reg;
            m_data_reg[275:266] <= hits_reg;
            m_data_reg[279:276] <= mask_reg;
        end
    end

    tswm_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .hi      (mul_hi),
        .lo      (mul_lo)
    );

    tswm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_q)
    );

    tswm_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_q),
        .busy     (sqrt_busy),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({mul_busy, div_busy, sqrt_busy}))
        else $error("arithmetic units busy at once");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_CHECK)
        else $error("accepted segment did not start");

    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && emit_ok) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented");

    a_busy_unit_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_busy || div_busy || sqrt_busy) |-> state_reg != ST_IDLE)
        else $error("unit running while idle");

endmodule
`default_nettype wire

@@ rtl/tswm_mul.sv @@
`default_nettype none
module tswm_mul (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [31:0] b,
    output logic             busy,
    output logic             done,
    output logic [63:0]      hi,
    output logic [31:0]      lo
);
    import tswm_pkg::*;

    logic [63:0] a_reg;
    logic [63:0] acc_reg;
    logic [31:0] lo_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] sum;

    // shift-add, one multiplier bit per cycle, LSB first
    always_comb begin
        sum = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, a_reg} : 65'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            acc_reg <= '0;
            lo_reg  <= b;
        end else if (busy_reg) begin
            acc_reg <= sum[64:1];
            lo_reg  <= {sum[0], lo_reg[31:1]};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign hi   = acc_reg;
    assign lo   = lo_reg;

endmodule
`default_nettype wire

@@ rtl/tswm_div.sv @@
`default_nettype none
module tswm_div (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [127:0] num,
    input  wire logic [63:0]  den,
    output logic              busy,
    output logic              done,
    output logic [63:0]       quot
);
    import tswm_pkg::*;

    logic [127:0] num_reg;
    logic [63:0]  den_reg;
    logic [63:0]  r_reg;
    logic [63:0]  q_reg;
    logic         sat_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [63:0]  rs;
    logic         ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rs = {r_reg[62:0], num_reg[127]};
        ge = r_reg[63] || (rs >= den_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            r_reg   <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[126:0], 1'b0};
            r_reg   <= ge ? (rs - den_reg) : rs;
            sat_reg <= sat_reg | q_reg[63];
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = sat_reg ? '1 : q_reg;

endmodule
`default_nettype wire

@@ rtl/tswm_sqrt.sv @@
`default_nettype none
module tswm_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             busy,
    output logic             done,
    output logic [31:0]      root
);
    import tswm_pkg::*;

    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;
    logic        ge;

    // digit-by-digit root, one result bit per cycle
    always_comb begin
        trial = res_reg + bit_reg;
        ge    = v_reg >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (ge) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule
`default_nettype wire
